>>> sv/usbkbd_pkg.sv
package usbkbd_pkg;

   localparam logic [7:0] KIND_INTERFACE = 8'd4;
   localparam logic [7:0] KIND_ENDPOINT  = 8'd5;
   localparam logic [7:0] CLASS_HID      = 8'd3;
   localparam logic [7:0] SUBCLASS_BOOT  = 8'd1;
   localparam logic [7:0] PROTOCOL_KBD   = 8'd1;
   localparam logic [1:0] XFER_INTERRUPT = 2'b11;
   localparam int         EP_DIR_IN_BIT  = 7;
   localparam logic [7:0] MIN_DESC_LEN   = 8'd2;

   localparam logic [6:0] ADDR_RESET     = 7'd1;
   localparam logic       SPEED_RESET    = 1'b0;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_LOW_SPEED      = 1'b1;

   localparam int RSP_BITS = 62;
   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic [6:0] device_address;
      logic       low_speed;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  byte_position;
      logic [7:0]  descriptor_length;
      logic [7:0]  descriptor_kind;
      logic        first_descriptor;
      logic [7:0]  interfaces_declared;
      logic [7:0]  interfaces_seen;
      logic [7:0]  endpoints_left;
      logic        interface_is_keyboard;
      logic [31:0] field_capture;
      logic        found_flag;
      logic [3:0]  found_endpoint;
      logic [15:0] found_packet_size;
      logic [7:0]  saved_config_value;
      logic        error_flag;
   } walk_type;

   localparam walk_type WALK_RESET = '{
      byte_position:         8'd0,
      descriptor_length:     8'd0,
      descriptor_kind:       8'd0,
      first_descriptor:      1'b1,
      interfaces_declared:   8'd0,
      interfaces_seen:       8'd0,
      endpoints_left:        8'd0,
      interface_is_keyboard: 1'b0,
      field_capture:         32'd0,
      found_flag:            1'b0,
      found_endpoint:        4'd0,
      found_packet_size:     16'd0,
      saved_config_value:    8'd0,
      error_flag:            1'b0
   };

   typedef struct packed {
      logic        malformed;
      logic [31:0] endpoint_flags;
      logic [15:0] max_packet_size;
      logic [3:0]  endpoint_number;
      logic [7:0]  config_value;
      logic        keyboard_found;
   } rsp_type;

endpackage

>>> sv/usb_boot_keyboard_descriptor_scan_top.sv
// Boot keyboard scan of a USB configuration descriptor set. Feed the set one
// byte per req beat, with req_tlast on its final byte; the block walks the
// descriptors by their length bytes and, on that last beat, queues one rsp
// beat with the config value, the first interrupt IN endpoint of a boot
// keyboard interface (class 3/1/1), its max packet size, the packed endpoint
// flags and a malformed flag for a length below two or a set that ends inside
// a descriptor. The walk state updates in a single registered step, so a
// byte can be taken every cycle while req_tready is high. Results sit in a
// two-deep output queue; req_tready drops only while both entries are full.
// Address and speed registers are written through csr_ and apply to the
// next result; write them only while the block is idle.
module usb_boot_keyboard_descriptor_scan_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] keyboard_found, [8:1] config_value, [12:9] endpoint_number,
   // [28:13] max_packet_size, [60:29] endpoint_flags, [61] malformed
   output logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   usbkbd_pkg::cfg_type cfg_ff, cfg_in;
   usbkbd_pkg::rsp_type walk_rsp, q_rsp;
   logic                walk_rsp_valid;
   logic                beat;
   logic                can_push;

   assign req_tready = can_push;
   assign beat       = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            usbkbd_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            usbkbd_pkg::CSR_LOW_SPEED:      cfg_in.low_speed      = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= usbkbd_pkg::ADDR_RESET;
         cfg_ff.low_speed      <= usbkbd_pkg::SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   usbkbd_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .cfg       (cfg_ff),
      .rsp_valid (walk_rsp_valid),
      .rsp       (walk_rsp)
   );

   usbkbd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (walk_rsp_valid),
      .push_data (walk_rsp),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_rsp)
   );

   assign rsp_tdata = {{(usbkbd_pkg::RSP_DATA_W - usbkbd_pkg::RSP_BITS){1'b0}}, q_rsp};

endmodule

>>> sv/usbkbd_walker.sv
module usbkbd_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               beat,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   input  usbkbd_pkg::cfg_type cfg,
   output logic               rsp_valid,
   output usbkbd_pkg::rsp_type rsp
);

   usbkbd_pkg::walk_type st_ff, st_in;
   usbkbd_pkg::walk_type nx;
   logic                 err_final;

   always_comb begin
      logic [1:0] lane;
      logic       cap_hit;
      logic [7:0] b;
      b       = data_byte;
      nx      = st_ff;
      lane    = 2'd0;
      cap_hit = 1'b0;
      if (!st_ff.error_flag) begin
         if (st_ff.byte_position == 8'd0) begin
            if (b < usbkbd_pkg::MIN_DESC_LEN) begin
               nx.error_flag = 1'b1;
            end else begin
               nx.descriptor_length = b;
               nx.descriptor_kind   = 8'd0;
               nx.field_capture     = 32'd0;
               nx.byte_position     = 8'd1;
            end
         end else begin
            if (st_ff.byte_position == 8'd1) begin
               nx.descriptor_kind = b;
            end
            if (nx.first_descriptor || nx.descriptor_kind == usbkbd_pkg::KIND_INTERFACE) begin
               cap_hit = (st_ff.byte_position >= 8'd4) && (st_ff.byte_position <= 8'd7);
               lane    = st_ff.byte_position[1:0];
            end else if (nx.descriptor_kind == usbkbd_pkg::KIND_ENDPOINT) begin
               cap_hit = (st_ff.byte_position >= 8'd2) && (st_ff.byte_position <= 8'd5);
               lane    = 2'(st_ff.byte_position - 8'd2);
            end
            if (cap_hit) begin
               nx.field_capture[8*lane +: 8] = nx.field_capture[8*lane +: 8] | b;
            end
            if (({1'b0, st_ff.byte_position} + 9'd1) >= {1'b0, st_ff.descriptor_length}) begin
               nx.byte_position = 8'd0;
               if (nx.first_descriptor) begin
                  nx.interfaces_declared = nx.field_capture[7:0];
                  nx.saved_config_value  = nx.field_capture[15:8];
                  nx.first_descriptor    = 1'b0;
               end else if (nx.descriptor_kind == usbkbd_pkg::KIND_INTERFACE) begin
                  if (nx.interfaces_seen < nx.interfaces_declared) begin
                     nx.interfaces_seen       = nx.interfaces_seen + 8'd1;
                     nx.endpoints_left        = nx.field_capture[7:0];
                     nx.interface_is_keyboard =
                        (nx.field_capture[15:8]  == usbkbd_pkg::CLASS_HID) &&
                        (nx.field_capture[23:16] == usbkbd_pkg::SUBCLASS_BOOT) &&
                        (nx.field_capture[31:24] == usbkbd_pkg::PROTOCOL_KBD);
                  end else begin
                     nx.endpoints_left        = 8'd0;
                     nx.interface_is_keyboard = 1'b0;
                  end
               end else if (nx.descriptor_kind == usbkbd_pkg::KIND_ENDPOINT) begin
                  if (nx.endpoints_left != 8'd0) begin
                     nx.endpoints_left = nx.endpoints_left - 8'd1;
                     if (!nx.found_flag && nx.interface_is_keyboard &&
                         (nx.field_capture[9:8] == usbkbd_pkg::XFER_INTERRUPT) &&
                         nx.field_capture[usbkbd_pkg::EP_DIR_IN_BIT]) begin
                        nx.found_flag        = 1'b1;
                        nx.found_endpoint    = nx.field_capture[3:0];
                        nx.found_packet_size = nx.field_capture[31:16];
                     end
                  end
               end
            end else begin
               nx.byte_position = st_ff.byte_position + 8'd1;
            end
         end
      end
   end

   // length below two earlier, or set ends mid-descriptor
   assign err_final = nx.error_flag || (nx.byte_position != 8'd0);

   always_comb begin
      rsp_valid           = beat && last_byte;
      rsp.keyboard_found  = nx.found_flag;
      rsp.config_value    = nx.saved_config_value;
      rsp.endpoint_number = nx.found_flag ? nx.found_endpoint : 4'd0;
      rsp.max_packet_size = nx.found_flag ? nx.found_packet_size : 16'd0;
      rsp.endpoint_flags  = nx.found_flag ?
         {nx.found_packet_size, 2'b00, cfg.low_speed, 2'b00, nx.found_endpoint,
          cfg.device_address} : 32'd0;
      rsp.malformed       = err_final;
   end

   always_comb begin
      st_in = st_ff;
      if (beat) begin
         st_in = last_byte ? usbkbd_pkg::WALK_RESET : nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= usbkbd_pkg::WALK_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

>>> sv/usbkbd_rsp_queue.sv
module usbkbd_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  usbkbd_pkg::rsp_type push_data,
   output logic               can_push,
   output logic               out_valid,
   input  logic               out_ready,
   output usbkbd_pkg::rsp_type out_data
);

   logic                head_valid_ff, head_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   usbkbd_pkg::rsp_type head_ff, head_in;
   usbkbd_pkg::rsp_type skid_ff, skid_in;
   logic                pop;

   assign pop       = head_valid_ff && out_ready;
   assign can_push  = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff || pop) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

>>> dv/usbkbd_scan_checker.sv
module usbkbd_scan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   output int          errors,
   output int          pending
);

   // scan state
   logic [7:0]  pos, dlen, dkind, ifc_decl, ifc_seen, ep_left, cfg_val;
   logic        first, kbd, found, bad;
   logic [31:0] cap;
   logic [3:0]  fep;
   logic [15:0] fmps;

   logic [6:0]  dev_addr;
   logic        slow;

   usbkbd_pkg::rsp_type reports[$];

   initial errors = 0;
   initial pending = 0;

   task automatic clear_scan();
      pos = '0; dlen = '0; dkind = '0; first = 1'b1;
      ifc_decl = '0; ifc_seen = '0; ep_left = '0; kbd = 1'b0;
      cap = '0; found = 1'b0; fep = '0; fmps = '0; cfg_val = '0; bad = 1'b0;
   endtask

   task automatic close_descriptor();
      if (first) begin
         ifc_decl = cap[7:0];
         cfg_val  = cap[15:8];
         first    = 1'b0;
      end else if (dkind == usbkbd_pkg::KIND_INTERFACE) begin
         if (ifc_seen < ifc_decl) begin
            ifc_seen = ifc_seen + 8'd1;
            ep_left  = cap[7:0];
            kbd = (cap[15:8] == usbkbd_pkg::CLASS_HID) &&
                  (cap[23:16] == usbkbd_pkg::SUBCLASS_BOOT) &&
                  (cap[31:24] == usbkbd_pkg::PROTOCOL_KBD);
         end else begin
            ep_left = '0;
            kbd     = 1'b0;
         end
      end else if (dkind == usbkbd_pkg::KIND_ENDPOINT) begin
         if (ep_left != 0) begin
            ep_left = ep_left - 8'd1;
            if (!found && kbd && cap[9:8] == usbkbd_pkg::XFER_INTERRUPT &&
                cap[usbkbd_pkg::EP_DIR_IN_BIT]) begin
               found = 1'b1;
               fep   = cap[3:0];
               fmps  = cap[31:16];
            end
         end
      end
   endtask

   task automatic scan_byte(input logic [7:0] b);
      if (bad) begin
      end else if (pos == 0) begin
         if (b < usbkbd_pkg::MIN_DESC_LEN) begin
            bad = 1'b1;
         end else begin
            dlen  = b;
            dkind = '0;
            cap   = '0;
            pos   = 8'd1;
         end
      end else begin
         if (pos == 1) dkind = b;
         if (first || dkind == usbkbd_pkg::KIND_INTERFACE) begin
            if (pos >= 4 && pos <= 7) cap = cap | (32'(b) << (8 * (int'(pos) - 4)));
         end else if (dkind == usbkbd_pkg::KIND_ENDPOINT) begin
            if (pos >= 2 && pos <= 5) cap = cap | (32'(b) << (8 * (int'(pos) - 2)));
         end
         if (int'(pos) + 1 >= int'(dlen)) begin
            close_descriptor();
            pos = '0;
         end else begin
            pos = pos + 8'd1;
         end
      end
   endtask

   function automatic usbkbd_pkg::rsp_type scan_report();
      usbkbd_pkg::rsp_type r;
      r = '0;
      r.keyboard_found = found;
      r.config_value   = cfg_val;
      r.malformed      = bad || (pos != 0);
      if (found) begin
         r.endpoint_number = fep;
         r.max_packet_size = fmps;
         r.endpoint_flags  = {fmps, 2'b00, slow, 2'b00, fep, dev_addr};
      end
      return r;
   endfunction

   always @(posedge clock) begin
      usbkbd_pkg::rsp_type got, want;
      if (reset) begin
         dev_addr = usbkbd_pkg::ADDR_RESET;
         slow     = usbkbd_pkg::SPEED_RESET;
         clear_scan();
         reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = usbkbd_pkg::rsp_type'(rsp_tdata[usbkbd_pkg::RSP_BITS-1:0]);
            if (reports.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: rsp beat with nothing expected: %h", $realtime, rsp_tdata);
            end else begin
               want = reports.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $write("%0t: rsp mismatch exp kbd=%0d cfg=%h ep=%h mps=%h flags=%h ",
                            $realtime, want.keyboard_found, want.config_value,
                            want.endpoint_number, want.max_packet_size,
                            want.endpoint_flags);
                     $display("bad=%0d / got kbd=%0d cfg=%h ep=%h mps=%h flags=%h bad=%0d",
                              want.malformed, got.keyboard_found, got.config_value,
                              got.endpoint_number, got.max_packet_size,
                              got.endpoint_flags, got.malformed);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata);
            if (req_tlast) begin
               reports.push_back(scan_report());
               clear_scan();
            end
         end
         if (csr_we) begin
            if (csr_index == usbkbd_pkg::CSR_DEVICE_ADDRESS) dev_addr = csr_wdata;
            else if (csr_index == usbkbd_pkg::CSR_LOW_SPEED) slow = csr_wdata[0];
         end
      end
      pending <= reports.size();
   end

endmodule

>>> dv/tb.sv
module tb;

   localparam logic [7:0] KIND_CONFIG = 8'h02;
   localparam logic [7:0] KIND_HID    = 8'h21;
   localparam int         HOLD_CYCLES = 600;
   localparam int         PHASE_BYTES = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = usbkbd_pkg::CSR_DEVICE_ADDRESS;
   logic [6:0]  csr_wdata = '0;

   int          check_errors, expected_left;
   int          snd_idle = 0, rcv_idle = 0;
   int          bytes_sent = 0, sets_sent = 0, csr_settings = 0;
   logic        hold_req = 1'b0, hold_seen = 1'b0;
   int          hold_cnt = 0;
   logic [7:0]  set_bytes[$];

   usb_boot_keyboard_descriptor_scan_top dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata
   );

   usbkbd_scan_checker scan_chk (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata,
      .errors(check_errors), .pending(expected_left)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off on each toggle of hold_req
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_cnt   <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt   <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic l);
      int gap;
      gap = 0;
      while ($urandom_range(99) < snd_idle && gap < 20) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_set();
      foreach (set_bytes[i]) send_beat(set_bytes[i], i == set_bytes.size() - 1);
      sets_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (expected_left == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [6:0] addr, input logic [6:0] speed_word);
      csr_we    <= 1'b1;
      csr_index <= usbkbd_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata <= addr;
      @(posedge clock);
      csr_index <= usbkbd_pkg::CSR_LOW_SPEED;
      csr_wdata <= speed_word;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_settings++;
   endtask

   function automatic int pick_len(input int nominal);
      int r;
      r = $urandom_range(999);
      if (r < 700) return nominal;
      if (r < 850) return $urandom_range(2, nominal - 1);
      if (r < 995) return $urandom_range(nominal + 1, nominal + 6);
      return 255;
   endfunction

   task automatic add_desc(input logic [7:0] d[9]);
      for (int i = 0; i < int'(d[0]); i++) set_bytes.push_back(i < 9 ? d[i] : 8'($urandom));
   endtask

   // mostly well-formed sets with random content, some noise and broken ones
   task automatic make_set();
      logic [7:0] d[9];
      int         n_ifc, n_ep, cut;
      set_bytes.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 24)) set_bytes.push_back(8'($urandom));
      end else begin
         foreach (d[i]) d[i] = 8'($urandom);
         n_ifc = $urandom_range(0, 3);
         d[0] = 8'(pick_len(9));
         d[1] = KIND_CONFIG;
         d[4] = ($urandom_range(99) < 10) ? 8'($urandom) : 8'(n_ifc);
         add_desc(d);
         for (int k = 0; k < n_ifc + ($urandom_range(99) < 15); k++) begin
            foreach (d[i]) d[i] = 8'($urandom);
            n_ep = $urandom_range(0, 3);
            d[0] = 8'(pick_len(9));
            d[1] = ($urandom_range(99) < 95) ? usbkbd_pkg::KIND_INTERFACE : 8'($urandom);
            d[4] = ($urandom_range(99) < 10) ? 8'($urandom) : 8'(n_ep);
            if ($urandom_range(99) < 85) d[5] = usbkbd_pkg::CLASS_HID;
            if ($urandom_range(99) < 85) d[6] = usbkbd_pkg::SUBCLASS_BOOT;
            if ($urandom_range(99) < 85) d[7] = usbkbd_pkg::PROTOCOL_KBD;
            add_desc(d);
            if ($urandom_range(1)) begin
               foreach (d[i]) d[i] = 8'($urandom);
               d[0] = 8'(pick_len(9));
               d[1] = KIND_HID;
               add_desc(d);
            end
            for (int e = 0; e < n_ep + ($urandom_range(99) < 10); e++) begin
               foreach (d[i]) d[i] = 8'($urandom);
               d[0] = 8'(pick_len(7));
               d[1] = ($urandom_range(99) < 95) ? usbkbd_pkg::KIND_ENDPOINT : 8'($urandom);
               if ($urandom_range(99) < 70) d[2][usbkbd_pkg::EP_DIR_IN_BIT] = 1'b1;
               if ($urandom_range(99) < 70) d[3][1:0] = usbkbd_pkg::XFER_INTERRUPT;
               add_desc(d);
            end
         end
         if ($urandom_range(99) < 6)
            set_bytes.insert($urandom_range(set_bytes.size() - 1),
                             8'($urandom_range(0, usbkbd_pkg::MIN_DESC_LEN - 1)));
         if ($urandom_range(99) < 6) begin
            cut = $urandom_range(1, set_bytes.size() - 1);
            while (set_bytes.size() > cut) void'(set_bytes.pop_back());
         end
      end
   endtask

   task automatic random_sets();
      int start_bytes, start_sets;
      start_bytes = bytes_sent;
      start_sets  = sets_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES || sets_sent - start_sets < 2) begin
         make_set();
         send_set();
      end
   endtask

   initial begin
      #3200000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      snd_idle = 19;
      rcv_idle = 71;

      // boot keyboard on endpoint 15, packet size all ones, reset address/speed
      set_bytes = {8'd6, KIND_CONFIG, 8'h00, 8'h00, 8'd1, 8'hFF,
                   8'd8, usbkbd_pkg::KIND_INTERFACE, 8'h00, 8'h00, 8'd1,
                   usbkbd_pkg::CLASS_HID, usbkbd_pkg::SUBCLASS_BOOT,
                   usbkbd_pkg::PROTOCOL_KBD,
                   8'd6, usbkbd_pkg::KIND_ENDPOINT, 8'h8F,
                   8'(usbkbd_pkg::XFER_INTERRUPT), 8'hFF, 8'hFF};
      send_set();
      // zero length byte
      set_bytes = {8'h00};
      send_set();
      // set ends inside a long descriptor
      set_bytes = {8'hFF, 8'hFF};
      send_set();
      // length one, then ignored bytes
      set_bytes = {8'd1, 8'h55, 8'hAA};
      send_set();

      for (int mode = 0; mode < 3; mode++) begin
         snd_idle = (mode == 0) ? 19 : (mode == 1) ? 71 : 0;
         rcv_idle = (mode == 0) ? 71 : (mode == 1) ? 19 : 0;
         for (int s = 0; s < 3; s++) begin
            settle();
            if (mode == 0 && s == 0) write_csr(7'h7F, 7'h7F);
            else if (mode == 0 && s == 1) write_csr(7'h00, 7'h7E);
            else write_csr(7'($urandom), 7'($urandom));
            if ((mode == 1 && s == 1) || (mode == 2 && s == 0)) hold_req <= ~hold_req;
            random_sets();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (expected_left == 0);
      repeat (8) @(posedge clock);
      $display("sent %0d bytes in %0d descriptor sets under %0d register settings,",
               bytes_sent, sets_sent, csr_settings);
      $display("three stall mixes and two long result hold-offs");
      if (check_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", check_errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
